[hw/rtl/json_string_field_extractor_top_assert.svh]
// Assertion macros for the JSON string field extractor.
`ifndef JSON_STRING_FIELD_EXTRACTOR_TOP_ASSERT_SVH
`define JSON_STRING_FIELD_EXTRACTOR_TOP_ASSERT_SVH
// Implication checked on every clock, masked during reset.
`define JSFE_ASSERT_IMPL(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// Next-cycle implication, masked during reset.
`define JSFE_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`endif

[hw/rtl/jsfe_pkg.sv]
// Shared types, constants and functions of the JSON string field extractor.
package jsfe_pkg;
  localparam int unsigned MaxKeyChars = 16;
  localparam int unsigned HexDigits   = 4;
  localparam int unsigned MaxResults  = 5;

  localparam logic [1:0] CfgKeyLow  = 2'd0;
  localparam logic [1:0] CfgKeyHigh = 2'd1;
  localparam logic [1:0] CfgKeyLen  = 2'd2;

  localparam logic [1:0] KindUnit = 2'd0;
  localparam logic [1:0] KindDone = 2'd1;
  localparam logic [1:0] KindStop = 2'd2;

  typedef enum logic [6:0] {
    PH_SEARCH = 7'b0000001,
    PH_COLON  = 7'b0000010,
    PH_SPACE  = 7'b0000100,
    PH_VALUE  = 7'b0001000,
    PH_ESCAPE = 7'b0010000,
    PH_HEX    = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] code_unit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] decoded_unit;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  count;
    logic [4:0][18:0] res;
  } run_t;

  function automatic logic is_space(input logic [15:0] u);
    is_space = (u >= 16'h0009 && u <= 16'h000D) || u == 16'h0020 || u == 16'h0085 ||
               u == 16'h00A0 || u == 16'h1680 || (u >= 16'h2000 && u <= 16'h200A) ||
               u == 16'h2028 || u == 16'h2029 || u == 16'h202F || u == 16'h205F ||
               u == 16'h3000;
  endfunction

  function automatic logic [4:0] hex_val(input logic [15:0] u);
    if (u >= 16'h0030 && u <= 16'h0039) hex_val = {1'b0, u[3:0]};
    else if ((u >= 16'h0061 && u <= 16'h0066) || (u >= 16'h0041 && u <= 16'h0046))
      hex_val = {1'b0, u[3:0] + 4'd9};
    else hex_val = 5'h10;
  endfunction

  function automatic logic [15:0] unescape(input logic [15:0] e);
    case (e)
      16'h006E: unescape = 16'h000A;
      16'h0074: unescape = 16'h0009;
      16'h0072: unescape = 16'h000D;
      16'h0062: unescape = 16'h0008;
      16'h0066: unescape = 16'h000C;
      default:  unescape = e;
    endcase
  endfunction
endpackage

[hw/rtl/jsfe_key_match.sv]
// Sliding window of recent code units and the quoted-key compare.
module jsfe_key_match #(
  parameter int unsigned MAX_KEY_CHARS = jsfe_pkg::MaxKeyChars
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  logic        shift,
  input  logic [15:0] unit,
  input  logic [63:0] key_low,
  input  logic [63:0] key_high,
  input  logic [4:0]  key_length,
  output logic        hit
);
  localparam int unsigned Depth = MAX_KEY_CHARS + 2;
  logic [15:0] win [Depth];
  logic [15:0] cand [Depth];
  logic [127:0] keys;
  logic [4:0] len;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < Depth; i++) win[i] <= '0;
    end else if (shift) begin
      win[0] <= unit;
      for (int i = 1; i < Depth; i++) win[i] <= win[i-1];
    end
  end

  // Compare against the window as it will look after this unit shifts in.
  always_comb begin
    cand[0] = unit;
    for (int i = 1; i < Depth; i++) cand[i] = win[i-1];
  end

  assign keys = {key_high, key_low};
  assign len = (key_length > 5'(MAX_KEY_CHARS)) ? 5'(MAX_KEY_CHARS) : key_length;

  always_comb begin
    hit = 1'b1;
    for (int j = 0; j < Depth; j++) begin
      if (j <= int'(len) + 1) begin
        if (j == 0 || j == int'(len) + 1) begin
          if (cand[int'(len) + 1 - j] != 16'h0022) hit = 1'b0;
        end else if (cand[int'(len) + 1 - j] != {8'h00, keys[8*(j-1) +: 8]}) begin
          hit = 1'b0;
        end
      end
    end
  end
endmodule

[hw/rtl/jsfe_decode.sv]
// Per-item decode of phase, escapes and \u runs into a result run.
module jsfe_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  jsfe_pkg::in_item_t item,
  input  logic              key_hit,
  output logic              in_search,
  output jsfe_pkg::run_t     run
);
  jsfe_pkg::phase_t phase, phase_next;
  logic [15:0] held [jsfe_pkg::HexDigits];
  logic [1:0] held_count, held_count_next;
  logic [15:0] u;

  function automatic logic [18:0] mk(input logic [1:0] k, input logic [15:0] d);
    mk = {k, d, 1'b0};
  endfunction

  assign u = item.code_unit;
  assign in_search = (phase == jsfe_pkg::PH_SEARCH);

  always_comb begin
    logic [4:0] h [4];
    logic [15:0] rep [4];
    logic ok, esc;
    phase_next = phase;
    held_count_next = held_count;
    run = '0;
    for (int i = 0; i < 4; i++) begin
      h[i] = '0;
      rep[i] = '0;
    end
    ok = 1'b0;
    esc = 1'b0;
    unique case (phase)
      jsfe_pkg::PH_SEARCH: if (key_hit) phase_next = jsfe_pkg::PH_COLON;
      jsfe_pkg::PH_COLON: if (u == 16'h003A) phase_next = jsfe_pkg::PH_SPACE;
      jsfe_pkg::PH_SPACE: begin
        if (!jsfe_pkg::is_space(u)) begin
          if (u == 16'h0022) phase_next = jsfe_pkg::PH_VALUE;
          else begin
            run.res[0] = mk(jsfe_pkg::KindStop, '0);
            run.count = 3'd1;
            phase_next = jsfe_pkg::PH_DONE;
          end
        end
      end
      jsfe_pkg::PH_VALUE: begin
        if (u == 16'h005C) phase_next = jsfe_pkg::PH_ESCAPE;
        else if (u == 16'h0022) begin
          run.res[0] = mk(jsfe_pkg::KindDone, '0);
          run.count = 3'd1;
          phase_next = jsfe_pkg::PH_DONE;
        end else begin
          run.res[0] = mk(jsfe_pkg::KindUnit, u);
          run.count = 3'd1;
        end
      end
      jsfe_pkg::PH_ESCAPE: begin
        if (u == 16'h0075) begin
          phase_next = jsfe_pkg::PH_HEX;
          held_count_next = '0;
        end else begin
          run.res[0] = mk(jsfe_pkg::KindUnit, jsfe_pkg::unescape(u));
          run.count = 3'd1;
          phase_next = jsfe_pkg::PH_VALUE;
        end
      end
      jsfe_pkg::PH_HEX: begin
        if (held_count != 2'd3) held_count_next = held_count + 2'd1;
        else begin
          rep[0] = held[0];
          rep[1] = held[1];
          rep[2] = held[2];
          rep[3] = u;
          ok = 1'b1;
          for (int i = 0; i < 4; i++) begin
            h[i] = jsfe_pkg::hex_val(rep[i]);
            if (h[i][4]) ok = 1'b0;
          end
          held_count_next = '0;
          phase_next = jsfe_pkg::PH_VALUE;
          if (ok) begin
            run.res[0] = mk(jsfe_pkg::KindUnit,
                            {h[0][3:0], h[1][3:0], h[2][3:0], h[3][3:0]});
            run.count = 3'd1;
          end else begin
            // Emit 'u', then replay the held units as value text.
            run.res[0] = mk(jsfe_pkg::KindUnit, 16'h0075);
            run.count = 3'd1;
            for (int i = 0; i < 4; i++) begin
              if (phase_next == jsfe_pkg::PH_VALUE) begin
                if (esc) begin
                  esc = 1'b0;
                  if (rep[i] == 16'h0075) begin
                    phase_next = jsfe_pkg::PH_HEX;
                    held_count_next = '0;
                  end else begin
                    run.res[run.count] = mk(jsfe_pkg::KindUnit,
                                            jsfe_pkg::unescape(rep[i]));
                    run.count = run.count + 3'd1;
                  end
                end else if (rep[i] == 16'h005C) esc = 1'b1;
                else if (rep[i] == 16'h0022) begin
                  run.res[run.count] = mk(jsfe_pkg::KindDone, '0);
                  run.count = run.count + 3'd1;
                  phase_next = jsfe_pkg::PH_DONE;
                end else begin
                  run.res[run.count] = mk(jsfe_pkg::KindUnit, rep[i]);
                  run.count = run.count + 3'd1;
                end
              end else if (phase_next == jsfe_pkg::PH_HEX) begin
                held_count_next = held_count_next + 2'd1;
              end
            end
            if (esc) phase_next = jsfe_pkg::PH_ESCAPE;
          end
        end
      end
      jsfe_pkg::PH_DONE: ;
      default: phase_next = jsfe_pkg::PH_SEARCH;
    endcase
    if (item.cmd) begin
      run = '0;
      phase_next = jsfe_pkg::PH_SEARCH;
      held_count_next = '0;
    end
    if (run.count != 3'd0) run.res[run.count - 3'd1][0] = 1'b1;
  end

  // Holds \u digits as they arrive; a replay into PH_HEX stores the replayed units as new held digits.
  always_ff @(posedge clk) begin
    if (step && phase == jsfe_pkg::PH_HEX && held_count != 2'd3)
      held[held_count] <= u;
    else if (step && phase == jsfe_pkg::PH_HEX && phase_next == jsfe_pkg::PH_HEX) begin
      // Units after the replayed 'u' escape become held digits.
      logic [15:0] rep2 [4];
      rep2[0] = held[0];
      rep2[1] = held[1];
      rep2[2] = held[2];
      rep2[3] = u;
      for (int i = 0; i < 4; i++)
        if (i >= 4 - int'(held_count_next)) held[i - (4 - int'(held_count_next))] <= rep2[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jsfe_pkg::PH_SEARCH;
      held_count <= '0;
    end else if (step) begin
      phase <= phase_next;
      held_count <= held_count_next;
    end
  end
endmodule

[hw/rtl/json_string_field_extractor_top.sv]
// Top level of the JSON string field extractor.
// Streaming extractor: one UTF-16 code unit enters per item and is decoded in the
// cycle it is accepted, so one item per cycle is sustained while in_stall is low.
// Each item yields zero to five result items; they leave one per cycle from a
// result run buffer while out_stall is low. Input stalls while a run of several
// results drains (only malformed \u replays give runs longer than one), and for
// as long as a waiting result is held back by out_stall. The buffer accepts a new
// item in the cycle its last result leaves. Configuration is written through a
// plain write port while the block is idle; the user must ensure this, unchecked.
module json_string_field_extractor_top #(
  parameter int unsigned MAX_KEY_CHARS = jsfe_pkg::MaxKeyChars
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  jsfe_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output jsfe_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  logic [63:0] key_low, key_high;
  logic [4:0] key_length;
  logic accept, hit, in_search;
  jsfe_pkg::run_t run, buf_run;
  logic [2:0] rd_ptr;
  logic last_out;

  function automatic jsfe_pkg::out_item_t out_item_from(input logic [18:0] r);
    out_item_from = r;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= '0;
      key_high <= '0;
      key_length <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jsfe_pkg::CfgKeyLow:  key_low <= cfg_data;
        jsfe_pkg::CfgKeyHigh: key_high <= cfg_data;
        jsfe_pkg::CfgKeyLen:  key_length <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Accept while the buffer is empty or releasing its last result.
  assign last_out = out_valid && !out_stall && (rd_ptr + 3'd1 == buf_run.count);
  assign in_stall = out_valid && !last_out;
  assign accept = in_valid && !in_stall;

  jsfe_key_match #(.MAX_KEY_CHARS(MAX_KEY_CHARS)) u_match (
    .clk, .rst,
    .clear(accept && in_data.cmd),
    .shift(accept && !in_data.cmd && in_search),
    .unit(in_data.code_unit),
    .key_low, .key_high, .key_length,
    .hit
  );

  jsfe_decode u_dec (
    .clk, .rst, .step(accept), .item(in_data), .key_hit(hit),
    .in_search, .run
  );

  // Hold the run and walk it out one result per cycle while out_stall is low.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_run.count <= '0;
      rd_ptr <= '0;
    end else if (accept) begin
      buf_run <= run;
      rd_ptr <= '0;
    end else if (last_out) begin
      buf_run.count <= '0;
      rd_ptr <= '0;
    end else if (out_valid && !out_stall) begin
      rd_ptr <= rd_ptr + 3'd1;
    end
  end

  assign out_valid = buf_run.count != 3'd0;
  assign out_data = out_item_from(buf_run.res[rd_ptr]);

`include "json_string_field_extractor_top_assert.svh"
  `JSFE_ASSERT_IMPL(a_stall_busy, clk, rst, in_stall, out_valid, "stall without results")
  `JSFE_ASSERT_IMPL(a_ptr_range, clk, rst, out_valid, rd_ptr < buf_run.count, "ptr past run")
  `JSFE_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped")
endmodule
